// ===== hw/rtl/kmp_pkg.sv =====
`timescale 1ns / 1ps

package kmp_pkg;

    localparam int BYTE_W       = 8;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_IDX_W    = 3;
    localparam int LENGTH_REG_W = 6;
    localparam int RESULT_POS_W = 32;
    localparam int NEEDLE_WORDS = 4;
    localparam int NEEDLE_W     = NEEDLE_WORDS * CFG_DATA_W;

    localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] NUM_REGS      = 3'd5;

    typedef struct packed {
        logic load;
        logic step;
        logic build_step;
    } t_cmd;

    typedef struct packed {
        logic cfg_hit;
        logic build_done;
        logic last;
        logic emit;
        logic out_free;
    } t_status;

endpackage

// ===== hw/rtl/kmp_ctrl.sv =====
`timescale 1ns / 1ps

module kmp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  kmp_pkg::t_status i_status,
    output kmp_pkg::t_cmd    o_cmd
);
    import kmp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_BUILD = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd            = '0;
        o_cmd.load       = (r_state == ST_IDLE) && i_in_valid && !i_status.cfg_hit;
        o_cmd.step       = (r_state == ST_SCAN) &&
                           (!i_status.last || !i_status.emit || i_status.out_free);
        o_cmd.build_step = (r_state == ST_BUILD) && !i_status.build_done &&
                           !i_status.cfg_hit;
        o_in_ready       = (r_state == ST_IDLE) && !i_status.cfg_hit;
    end

    always_comb begin
        n_state = r_state;
        if (i_status.cfg_hit) begin
            n_state = ST_BUILD;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (o_cmd.load) begin
                        n_state = ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (o_cmd.step && i_status.last) begin
                        n_state = ST_IDLE;
                    end
                end
                ST_BUILD: begin
                    if (i_status.build_done) begin
                        n_state = ST_IDLE;
                    end
                end
                default: n_state = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/kmp_datapath.sv =====
`timescale 1ns / 1ps

module kmp_datapath #(
    parameter int MAX_NEEDLE    = 32,
    parameter int POSITION_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [kmp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [kmp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [kmp_pkg::BYTE_W-1:0]      i_text_byte,
    input  logic                            i_text_start,
    input  logic                            i_text_end,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_found,
    output logic [kmp_pkg::RESULT_POS_W-1:0] o_match_position,
    input  kmp_pkg::t_cmd                   i_cmd,
    output kmp_pkg::t_status                o_status
);
    import kmp_pkg::*;

    localparam int LEN_W = $clog2(MAX_NEEDLE + 1);
    localparam int IDX_W = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
    localparam int POS_W = POSITION_BITS;

    logic [CFG_DATA_W-1:0]   r_needle [NEEDLE_WORDS];
    logic [LENGTH_REG_W-1:0] r_len_reg;
    logic [LEN_W-1:0]        r_fail [MAX_NEEDLE];
    logic [LEN_W-1:0]        r_j;
    logic [LEN_W-1:0]        r_bi;
    logic [LEN_W-1:0]        r_bj;
    logic [POS_W-1:0]        r_pos;
    logic                    r_done;
    logic [BYTE_W-1:0]       r_byte;
    logic                    r_end;
    logic                    r_out_valid;
    logic                    r_found;
    logic [RESULT_POS_W-1:0] r_out_pos;

    logic [NEEDLE_W-1:0]     needle_flat;
    logic [LEN_W-1:0]        len;
    logic                    cfg_hit;
    logic [5:0]              bi6;
    logic [5:0]              bj6;
    logic [5:0]              j6;
    logic [BYTE_W-1:0]       nb_bi;
    logic [BYTE_W-1:0]       nb_bj;
    logic [BYTE_W-1:0]       nb_j;
    logic                    b_eq;
    logic                    b_fall;
    logic [LEN_W-1:0]        b_next_j;
    logic [LEN_W-1:0]        rd_base;
    logic [IDX_W-1:0]        rd_addr;
    logic [LEN_W-1:0]        fail_rd;
    logic                    s_eq;
    logic                    s_fall;
    logic [LEN_W-1:0]        s_jinc;
    logic                    hit;
    logic                    emit;
    logic [POS_W-1:0]        back;
    logic [POS_W-1:0]        mp;
    logic                    out_free;

    always_comb begin
        for (int w = 0; w < NEEDLE_WORDS; w++) begin
            needle_flat[w*CFG_DATA_W +: CFG_DATA_W] = r_needle[w];
        end
    end

    assign len = (r_len_reg > LENGTH_REG_W'(MAX_NEEDLE)) ? LEN_W'(MAX_NEEDLE)
                                                          : LEN_W'(r_len_reg);
    assign cfg_hit = i_cfg_we && (i_cfg_index < NUM_REGS);

    assign bi6   = 6'(r_bi);
    assign bj6   = 6'(r_bj);
    assign j6    = 6'(r_j);
    assign nb_bi = needle_flat[{bi6[4:0], 3'b000} +: BYTE_W];
    assign nb_bj = needle_flat[{bj6[4:0], 3'b000} +: BYTE_W];
    assign nb_j  = needle_flat[{j6[4:0], 3'b000} +: BYTE_W];

    // One read port on the failure table, shared by the table build and the search.
    assign rd_base = i_cmd.build_step ? r_bj : r_j;
    assign rd_addr = IDX_W'(rd_base - LEN_W'(1));
    assign fail_rd = (rd_addr == '0) ? '0 : r_fail[rd_addr];

    assign b_eq     = (nb_bi == nb_bj);
    assign b_fall   = (r_bj != '0) && !b_eq;
    assign b_next_j = LEN_W'(r_bj + LEN_W'(b_eq));

    assign s_eq   = (nb_j == r_byte);
    assign s_fall = (len != '0) && !r_done && (r_j != '0) && !s_eq;
    assign s_jinc = LEN_W'(r_j + LEN_W'(s_eq));
    assign hit    = (len == '0) || (s_jinc == len);
    assign emit   = !r_done && (hit || r_end);

    assign back = (len == '0) ? '0 : POS_W'(len) - POS_W'(1);
    assign mp   = (r_pos >= back) ? (r_pos - back) : '0;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_status            = '0;
        o_status.cfg_hit    = cfg_hit;
        o_status.build_done = (r_bi >= len);
        o_status.last       = !s_fall;
        o_status.emit       = emit;
        o_status.out_free   = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < NEEDLE_WORDS; w++) begin
                r_needle[w] <= '0;
            end
            r_len_reg   <= '0;
            r_j         <= '0;
            r_bi        <= LEN_W'(1);
            r_bj        <= '0;
            r_pos       <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.build_step) begin
                if (b_fall) begin
                    r_bj <= fail_rd;
                end else begin
                    r_bj <= b_next_j;
                    r_bi <= LEN_W'(r_bi + LEN_W'(1));
                end
            end

            if (i_cmd.load) begin
                if (i_text_start) begin
                    r_j    <= '0;
                    r_pos  <= '0;
                    r_done <= 1'b0;
                end else if (r_j >= len) begin
                    r_j <= '0;
                end
            end

            if (i_cmd.step) begin
                if (s_fall) begin
                    r_j <= fail_rd;
                end else if (!r_done) begin
                    if (len != '0) begin
                        r_j <= s_jinc;
                    end
                    if (r_pos != '1) begin
                        r_pos <= r_pos + POS_W'(1);
                    end
                    if (emit) begin
                        r_done <= 1'b1;
                    end
                end
            end

            if (i_cmd.step && !s_fall && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (cfg_hit) begin
                if (i_cfg_index == REG_LENGTH) begin
                    r_len_reg <= i_cfg_data[LENGTH_REG_W-1:0];
                end else begin
                    r_needle[i_cfg_index[1:0]] <= i_cfg_data;
                end
                r_j  <= '0;
                r_bi <= LEN_W'(1);
                r_bj <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.build_step && !b_fall) begin
            r_fail[IDX_W'(r_bi)] <= b_next_j;
        end
        if (i_cmd.load) begin
            r_byte <= i_text_byte;
            r_end  <= i_text_end;
        end
        if (i_cmd.step && !s_fall && emit) begin
            r_found   <= hit;
            r_out_pos <= hit ? RESULT_POS_W'(mp) : '0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_found          = r_found;
    assign o_match_position = r_out_pos;

endmodule

// ===== hw/rtl/kmp_first_match_search.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_ready   i_text_byte, i_text_start, i_text_end
// out       output     o_out_valid / i_out_ready o_found, o_match_position
// cfg       input      i_cfg_we                  i_cfg_index, i_cfg_data
//
// A text byte is taken in ST_IDLE and searched in ST_SCAN, which repeats for each failure-link
// fallback through the shared table read port; fallbacks average at most one per byte, and no
// new byte is taken until the search of the last one ends.
// A register write rebuilds the failure table in ST_BUILD, during which no byte is taken. Reset
// is synchronous and clears the needle, length and search state.
// A result waiting in the output register stalls only the item that produces the next result.

module kmp_first_match_search #(
    parameter int MAX_NEEDLE    = 32,
    parameter int POSITION_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [kmp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [kmp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [kmp_pkg::BYTE_W-1:0]       i_text_byte,
    input  logic                             i_text_start,
    input  logic                             i_text_end,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_found,
    output logic [kmp_pkg::RESULT_POS_W-1:0] o_match_position
);
    import kmp_pkg::*;

    t_cmd    cmd;
    t_status status;

    kmp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    kmp_datapath #(
        .MAX_NEEDLE    (MAX_NEEDLE),
        .POSITION_BITS (POSITION_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_text_byte      (i_text_byte),
        .i_text_start     (i_text_start),
        .i_text_end       (i_text_end),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_found          (o_found),
        .o_match_position (o_match_position),
        .i_cmd            (cmd),
        .o_status         (status)
    );

`ifndef ASSERT_OFF
    a_busy_after_transfer : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while the previous byte is still searched");

    a_busy_after_write : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_index < NUM_REGS)) |=> !o_in_ready)
        else $error("input ready during the failure table rebuild");

    a_not_found_position : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_match_position == '0))
        else $error("not-found result carries a nonzero position");
`endif

endmodule

// ===== tb/sv/tb_kmp_first_match_search.sv =====
`timescale 1ns / 1ps

module tb_kmp_first_match_search;

    import kmp_pkg::*;

    localparam int MAX_NEEDLE    = 32;
    localparam int POSITION_BITS = 32;
    localparam int RANDOM_ITEMS  = 800;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 4000;
    localparam int PLAN_ROWS     = 30;

    typedef enum logic {ROW_TEXT, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind                 kind;
        logic [BYTE_W-1:0]         data;
        logic                      first;
        logic                      last;
        logic                      fixed;
        logic                      fixed_found;
        logic [RESULT_POS_W-1:0]   fixed_pos;
        logic [CFG_IDX_W-1:0]      reg_idx;
        logic [CFG_DATA_W-1:0]     reg_val;
    } t_plan_row;

    typedef struct packed {
        logic                    found;
        logic [RESULT_POS_W-1:0] position;
    } t_text_outcome;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [BYTE_W-1:0]       i_text_byte;
    logic                    i_text_start;
    logic                    i_text_end;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic                    o_found;
    logic [RESULT_POS_W-1:0] o_match_position;

    logic [CFG_DATA_W-1:0]    needle_word [NEEDLE_WORDS];
    logic [LENGTH_REG_W-1:0]  needle_len_reg;
    logic [LENGTH_REG_W-1:0]  partial_len;
    logic [POSITION_BITS-1:0] text_offset;
    bit                       outcome_given;
    int unsigned              border_table [MAX_NEEDLE];

    t_text_outcome expected_outcomes [$];
    int            error_count = 0;
    int            sent_bytes;
    int            stall_cycles;
    int            drain_hold;
    bit            feed_gaps = 1'b1;
    bit            drain_gaps = 1'b1;
    bit            hold_request;
    bit            hold_taken;

    t_plan_row directed_plan [PLAN_ROWS] = '{
        '{ROW_TEXT, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 32'd0, REG_NEEDLE_0, 64'd0},
        '{ROW_TEXT, 8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0, REG_NEEDLE_0, 64'd0},
        '{ROW_TEXT, 8'hA5, 1'b1, 1'b1, 1'b1, 1'b1, 32'd0, REG_NEEDLE_0, 64'd0},
        '{ROW_REG,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, REG_NEEDLE_0, 64'h0000_0000_00FF_0000},
        '{ROW_REG,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, REG_NEEDLE_1, 64'hFFFF_FFFF_FFFF_FFFF},
        '{ROW_REG,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, REG_NEEDLE_2, 64'h0},
        '{ROW_REG,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, REG_NEEDLE_3, 64'h8000_0000_0000_0001},
        '{ROW_REG,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, REG_LENGTH,   64'hFFFF_FFFF_FFFF_FFC3},
        '{ROW_TEXT, 8'h55, 1'b1, 1'b1, 1'b1, 1'b0, 32'd0, REG_NEEDLE_0, 64'd0},
        '{ROW_TEXT, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, REG_NEEDLE_0, 64'd0},
        '{ROW_TEXT, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, REG_NEEDLE_0, 64'd0},
        '{ROW_TEXT, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, REG_NEEDLE_0, 64'd0},
        '{ROW_TEXT, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, REG_NEEDLE_0, 64'd0},
        '{ROW_TEXT, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0, REG_NEEDLE_0, 64'd0},
        '{ROW_TEXT, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, REG_NEEDLE_0, 64'd0},
        '{ROW_TEXT, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, REG_NEEDLE_0, 64'd0},
        '{ROW_TEXT, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b1, 32'd0, REG_NEEDLE_0, 64'd0},
        '{ROW_TEXT, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, REG_NEEDLE_0, 64'd0},
        '{ROW_TEXT, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, REG_NEEDLE_0, 64'd0},
        '{ROW_TEXT, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, REG_NEEDLE_0, 64'd0},
        '{ROW_REG,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, REG_LENGTH,   64'h3F},
        '{ROW_TEXT, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, REG_NEEDLE_0, 64'd0},
        '{ROW_TEXT, 8'h80, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0, REG_NEEDLE_0, 64'd0},
        '{ROW_REG,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, REG_LENGTH,   64'h3},
        '{ROW_TEXT, 8'h10, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, REG_NEEDLE_0, 64'd0},
        '{ROW_TEXT, 8'h20, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, REG_NEEDLE_0, 64'd0},
        '{ROW_REG,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, REG_LENGTH,   64'h40},
        '{ROW_TEXT, 8'h30, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0, REG_NEEDLE_0, 64'd0},
        '{ROW_REG,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, NUM_REGS,     64'hFFFF_FFFF_FFFF_FFFF},
        '{ROW_TEXT, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 32'd0, REG_NEEDLE_0, 64'd0}
    };

    kmp_first_match_search #(
        .MAX_NEEDLE    (MAX_NEEDLE),
        .POSITION_BITS (POSITION_BITS)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_text_byte      (i_text_byte),
        .i_text_start     (i_text_start),
        .i_text_end       (i_text_end),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_found          (o_found),
        .o_match_position (o_match_position)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int unsigned used_len();
        return (needle_len_reg > MAX_NEEDLE) ? MAX_NEEDLE : int'(needle_len_reg);
    endfunction

    function automatic logic [BYTE_W-1:0] needle_byte(input int unsigned idx);
        int unsigned k;
        k = idx % MAX_NEEDLE;
        return needle_word[k / 8][(k % 8) * BYTE_W +: BYTE_W];
    endfunction

    function automatic void rebuild_borders();
        int unsigned n;
        int unsigned i;
        int unsigned j;
        n = used_len();
        j = 0;
        for (i = 0; i < MAX_NEEDLE; i++) begin
            border_table[i] = 0;
        end
        for (i = 1; i < n; i++) begin
            while (j > 0 && needle_byte(i) != needle_byte(j)) begin
                j = border_table[j - 1];
            end
            if (needle_byte(i) == needle_byte(j)) begin
                j++;
            end
            border_table[i] = j;
        end
    endfunction

    function automatic void clear_search_state();
        for (int w = 0; w < NEEDLE_WORDS; w++) begin
            needle_word[w] = '0;
        end
        needle_len_reg = '0;
        partial_len    = '0;
        text_offset    = '0;
        outcome_given  = 1'b0;
        rebuild_borders();
    endfunction

    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] value);
        if (idx <= REG_NEEDLE_3) begin
            needle_word[idx[1:0]] = value;
        end else if (idx == REG_LENGTH) begin
            needle_len_reg = value[LENGTH_REG_W-1:0];
        end else begin
            return;
        end
        rebuild_borders();
        partial_len = '0;
    endfunction

    function automatic void scan_byte(input logic [BYTE_W-1:0] value, input logic first,
                                      input logic last, output bit emits, output bit hit,
                                      output logic [RESULT_POS_W-1:0] at);
        int unsigned n;
        int unsigned j;
        int unsigned back;
        logic [POSITION_BITS-1:0] pos_now;
        n        = used_len();
        emits    = 1'b0;
        hit      = 1'b0;
        at       = '0;
        if (first) begin
            partial_len   = '0;
            text_offset   = '0;
            outcome_given = 1'b0;
        end
        pos_now = text_offset;
        if (outcome_given) begin
            return;
        end
        if (n == 0) begin
            hit = 1'b1;
        end else begin
            j = 32'(partial_len);
            if (j >= n) begin
                j = 0;
            end
            while (j > 0 && needle_byte(j) != value) begin
                j = border_table[j - 1];
            end
            if (needle_byte(j) == value) begin
                j++;
            end
            hit = (j == n);
            partial_len = j[LENGTH_REG_W-1:0];
        end
        if (text_offset != '1) begin
            text_offset++;
        end
        if (hit) begin
            back = (n > 0) ? n - 1 : 0;
            at = (pos_now >= back) ? RESULT_POS_W'(pos_now - back) : '0;
            emits = 1'b1;
            outcome_given = 1'b1;
        end else if (last) begin
            emits = 1'b1;
            outcome_given = 1'b1;
        end
    endfunction

    task automatic flag_error(input string what);
        error_count++;
        $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] value, input logic first,
                             input logic last, input logic fixed, input logic fixed_found,
                             input logic [RESULT_POS_W-1:0] fixed_pos);
        bit emits;
        bit hit;
        logic [RESULT_POS_W-1:0] at;
        t_text_outcome outcome;
        while (feed_gaps && $urandom_range(99) < 27) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_text_byte  <= value;
        i_text_start <= first;
        i_text_end   <= last;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        scan_byte(value, first, last, emits, hit, at);
        sent_bytes++;
        if (emits) begin
            outcome.found    = fixed ? fixed_found : hit;
            outcome.position = fixed ? fixed_pos : at;
            expected_outcomes.push_back(outcome);
        end
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        apply_reg_write(idx, value);
        @(negedge i_clk);
    endtask

    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        while (expected_outcomes.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            drain_hold = HOLD_CYCLES;
        end
        if (drain_hold > 0) begin
            drain_hold--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !(drain_gaps && $urandom_range(99) < 27);
        end
    end

    always @(posedge i_clk) begin : check_outcome
        t_text_outcome want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (expected_outcomes.size() == 0) begin
                flag_error("result transfer with no text outcome pending");
            end else begin
                want = expected_outcomes.pop_front();
                if (o_found !== want.found) begin
                    flag_error($sformatf("found %0b, expected %0b", o_found, want.found));
                end
                if (o_match_position !== want.position) begin
                    flag_error($sformatf("match position %0d, expected %0d",
                                         o_match_position, want.position));
                end
            end
        end
    end

    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid === 1'b1 && o_in_ready === 1'b1) ||
                (o_out_valid === 1'b1 && i_out_ready === 1'b1) || i_cfg_we === 1'b1) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("kmp_first_match_search verification failed");
        $finish;
    end

    initial begin
        int                      r;
        int                      k;
        int                      w;
        int                      t;
        int                      eff;
        int                      txt_len;
        int                      plant_at;
        int                      rewrite_at;
        int                      texts;
        int                      phase;
        int                      directed_sent;
        int unsigned             pick;
        int unsigned             mode;
        int unsigned             new_len;
        bit                      plant;
        bit                      spoil;
        bit                      noisy;
        bit                      wide_alpha;
        bit                      calm;
        logic                    first;
        logic                    last;
        logic [BYTE_W-1:0]       sym_a;
        logic [BYTE_W-1:0]       sym_b;
        logic [BYTE_W-1:0]       value;
        logic [NEEDLE_W-1:0]     pick_bits;
        logic [CFG_DATA_W-1:0]   len_data;
        t_plan_row               row;

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_text_byte  = '0;
        i_text_start = 1'b0;
        i_text_end   = 1'b0;
        sent_bytes   = 0;
        clear_search_state();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (r = 0; r < PLAN_ROWS; r++) begin
            row = directed_plan[r];
            if (row.kind == ROW_REG) begin
                if (r == 0 || directed_plan[r-1].kind != ROW_REG) begin
                    wait_quiet();
                end
                write_reg(row.reg_idx, row.reg_val);
                if (r == PLAN_ROWS - 1 || directed_plan[r+1].kind != ROW_REG) begin
                    i_cfg_we <= 1'b0;
                end
            end else begin
                send_byte(row.data, row.first, row.last, row.fixed, row.fixed_found,
                          row.fixed_pos);
            end
        end
        directed_sent = sent_bytes;

        phase = 0;
        while (sent_bytes < directed_sent + RANDOM_ITEMS) begin
            wait_quiet();
            mode       = $urandom_range(9);
            wide_alpha = ($urandom_range(2) == 0);
            sym_a      = BYTE_W'($urandom);
            sym_b      = BYTE_W'($urandom);
            for (k = 0; k < MAX_NEEDLE; k++) begin
                if (mode == 0) begin
                    value = 8'h00;
                end else if (mode == 1) begin
                    value = 8'hFF;
                end else if (wide_alpha) begin
                    value = BYTE_W'($urandom);
                end else begin
                    value = $urandom_range(1) ? sym_a : sym_b;
                end
                pick_bits[k*BYTE_W +: BYTE_W] = value;
            end
            pick = $urandom_range(99);
            if (pick < 8) begin
                new_len = 0;
            end else if (pick < 55) begin
                new_len = $urandom_range(4, 1);
            end else if (pick < 80) begin
                new_len = $urandom_range(12, 5);
            end else if (pick < 92) begin
                new_len = MAX_NEEDLE;
            end else begin
                new_len = $urandom_range((1 << LENGTH_REG_W) - 1, MAX_NEEDLE + 1);
            end
            for (w = 0; w < NEEDLE_WORDS; w++) begin
                if (phase == 0 || mode <= 1 || $urandom_range(3) != 0) begin
                    write_reg(REG_NEEDLE_0 + CFG_IDX_W'(w),
                              pick_bits[w*CFG_DATA_W +: CFG_DATA_W]);
                end
            end
            if ($urandom_range(7) == 0) begin
                write_reg(NUM_REGS + CFG_IDX_W'($urandom_range(2)), {$urandom, $urandom});
            end
            len_data = {$urandom, $urandom};
            len_data[LENGTH_REG_W-1:0] = new_len[LENGTH_REG_W-1:0];
            write_reg(REG_LENGTH, len_data);
            i_cfg_we <= 1'b0;

            // Hold the result side off while one-byte texts keep coming, so the block backs up.
            if (phase == 3) begin
                feed_gaps    = 1'b0;
                hold_request = 1'b1;
                repeat (40) send_byte(BYTE_W'($urandom), 1'b1, 1'b1, 1'b0, 1'b0, '0);
            end

            texts = $urandom_range(6, 1);
            for (t = 0; t < texts; t++) begin
                calm = (sent_bytes - directed_sent >= 300) &&
                       (sent_bytes - directed_sent < 450);
                feed_gaps  = !calm;
                drain_gaps = !calm;
                eff        = used_len();
                txt_len    = (eff == 0) ? $urandom_range(4, 1) : $urandom_range(eff + 12, 1);
                plant      = eff > 0 && txt_len >= eff && $urandom_range(99) < 65;
                plant_at   = plant ? $urandom_range(txt_len - eff) : 0;
                spoil      = ($urandom_range(4) == 0);
                noisy      = ($urandom_range(9) == 0);
                rewrite_at = ($urandom_range(19) == 0) ? $urandom_range(txt_len - 1) : -1;
                for (k = 0; k < txt_len; k++) begin
                    // A length change in the middle of a text restarts the match.
                    if (k == rewrite_at && k > 0) begin
                        wait_quiet();
                        len_data = {$urandom, $urandom};
                        len_data[LENGTH_REG_W-1:0] = LENGTH_REG_W'($urandom_range(8));
                        write_reg(REG_LENGTH, len_data);
                        i_cfg_we <= 1'b0;
                    end
                    if (plant && k >= plant_at && k < plant_at + eff) begin
                        value = needle_byte(k - plant_at);
                        if (spoil && k == plant_at + eff - 1) begin
                            value = ~value;
                        end
                    end else if (eff > 0 && $urandom_range(9) < 7) begin
                        value = needle_byte($urandom_range(eff - 1));
                    end else begin
                        value = BYTE_W'($urandom);
                    end
                    first = noisy ? ($urandom_range(3) == 0) : (k == 0);
                    last  = noisy ? ($urandom_range(3) == 0) : (k == txt_len - 1);
                    send_byte(value, first, last, 1'b0, 1'b0, '0);
                end
            end
            phase++;
        end

        wait_quiet();
        if (error_count == 0) begin
            $display("kmp_first_match_search verification clean");
        end else begin
            $display("kmp_first_match_search verification failed");
        end
        $finish;
    end

endmodule
